// File: hdl/clhc_pkg.sv
// Shared types and constants for the cluster label to hue colour block.
// No dependencies; imported by clhc_hue_div, clhc_rgb and cluster_label_to_hue_color.
package clhc_pkg;

    localparam int LABEL_IN_W      = 16;
    localparam int LABEL_WIDTH_DEF = 16;
    localparam int CNT_W           = 16;
    localparam int CH_W            = 8;

    // hue quotient, 0..179, produced DIV_BITS bits per stage
    localparam int QUO_W    = 8;
    localparam int DIV_BITS = 2;
    localparam int PROD_W   = LABEL_IN_W + QUO_W;

    localparam int HUE_FULL     = 180;
    localparam int SECTOR_STEPS = 30;
    localparam int FULL_SCALE   = 255;
    localparam int SCALE_DEN    = FULL_SCALE * SECTOR_STEPS;

    localparam int SEC_W  = 3;
    localparam int FRAC_W = 5;
    localparam int XQ_W   = 13;
    localparam int NQ_W   = CH_W + XQ_W;
    localparam int NP_W   = 2 * CH_W;

    // reciprocals for floor division by constants, one correction step after
    localparam int RECIP_DEN_SH = 32;
    localparam int RECIP_DEN_W  = 20;
    localparam logic [RECIP_DEN_W-1:0] RECIP_DEN =
        RECIP_DEN_W'((64'd1 << RECIP_DEN_SH) / 64'(SCALE_DEN));
    localparam int RECIP_FS_SH = 24;
    localparam int RECIP_FS_W  = 17;
    localparam logic [RECIP_FS_W-1:0] RECIP_FS =
        RECIP_FS_W'((64'd1 << RECIP_FS_SH) / 64'(FULL_SCALE));

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SATURATION    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS    = 2'd2;

    typedef struct packed {
        logic [QUO_W-1:0] quo;
        logic             sat;
        logic             noise;
    } hue_t;

endpackage

// File: hdl/clhc_hue_div.sv
// Hue index: label * 180 / cluster_count through a pipelined restoring divider.
// Depends on clhc_pkg.
module clhc_hue_div
    import clhc_pkg::*;
#(
    parameter int LABEL_WIDTH = LABEL_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [LABEL_IN_W-1:0] label,
    input  logic [CNT_W-1:0]      cluster_count,
    output logic                  hue_valid,
    input  logic                  hue_ready,
    output hue_t                  hue
);

    localparam int DIV_STAGES = QUO_W / DIV_BITS;
    localparam logic [LABEL_IN_W-1:0] LABEL_MASK = (LABEL_WIDTH >= LABEL_IN_W) ?
        {LABEL_IN_W{1'b1}} : LABEL_IN_W'((64'd1 << LABEL_WIDTH) - 64'd1);

    logic [DIV_STAGES:0] valid_reg;
    logic [DIV_STAGES:0] en;

    logic [CNT_W-1:0] rem_reg [DIV_STAGES+1];
    logic [QUO_W-1:0] low_reg [DIV_STAGES+1];
    logic [QUO_W-1:0] quo_reg [DIV_STAGES+1];
    logic             sat_reg [DIV_STAGES+1];
    logic             noise_reg [DIV_STAGES+1];

    logic [LABEL_IN_W-1:0] lab;
    logic [CNT_W-1:0]      cnt_eff;
    logic [PROD_W-1:0]     prod;

    assign lab     = label & LABEL_MASK;
    assign cnt_eff = (cluster_count == '0) ? CNT_W'(1) : cluster_count;
    assign prod    = PROD_W'(lab) * PROD_W'(HUE_FULL);

    always_comb
    begin
        en[DIV_STAGES] = !valid_reg[DIV_STAGES] || hue_ready;
        for (int k = DIV_STAGES - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k <= DIV_STAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0]   <= prod[PROD_W-1:QUO_W];
            low_reg[0]   <= prod[QUO_W-1:0];
            quo_reg[0]   <= '0;
            sat_reg[0]   <= (lab >= cnt_eff);
            noise_reg[0] <= (lab == '0);
        end
    end

    for (genvar g = 1; g <= DIV_STAGES; g++)
    begin : g_div
        logic [CNT_W-1:0] rem_next;
        logic [QUO_W-1:0] low_next;
        logic [QUO_W-1:0] quo_next;

        always_comb
        begin
            logic [CNT_W:0] trial;
            rem_next = rem_reg[g-1];
            low_next = low_reg[g-1];
            quo_next = quo_reg[g-1];
            for (int j = 0; j < DIV_BITS; j++)
            begin
                trial    = {rem_next, low_next[QUO_W-1]};
                low_next = {low_next[QUO_W-2:0], 1'b0};
                if (trial >= {1'b0, cnt_eff})
                begin
                    trial    = trial - {1'b0, cnt_eff};
                    quo_next = {quo_next[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_next[QUO_W-2:0], 1'b0};
                end
                rem_next = trial[CNT_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[g])
            begin
                rem_reg[g]   <= rem_next;
                low_reg[g]   <= low_next;
                quo_reg[g]   <= quo_next;
                sat_reg[g]   <= sat_reg[g-1];
                noise_reg[g] <= noise_reg[g-1];
            end
        end
    end

    assign hue_valid = valid_reg[DIV_STAGES];
    assign hue.quo   = quo_reg[DIV_STAGES];
    assign hue.sat   = sat_reg[DIV_STAGES];
    assign hue.noise = noise_reg[DIV_STAGES];

endmodule

// File: hdl/clhc_rgb.sv
// Hue to RGB conversion pipeline with exact floor scaling by 255.
// Depends on clhc_pkg; fed by clhc_hue_div.
module clhc_rgb
    import clhc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            hue_valid,
    output logic            hue_ready,
    input  hue_t            hue,
    input  logic [CH_W-1:0] saturation,
    input  logic [CH_W-1:0] brightness,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [CH_W-1:0] red,
    output logic [CH_W-1:0] green,
    output logic [CH_W-1:0] blue
);

    localparam int STAGES = 6;

    localparam logic [SEC_W-1:0] SEC_RY = 3'd0;
    localparam logic [SEC_W-1:0] SEC_YG = 3'd1;
    localparam logic [SEC_W-1:0] SEC_GC = 3'd2;
    localparam logic [SEC_W-1:0] SEC_CB = 3'd3;
    localparam logic [SEC_W-1:0] SEC_BM = 3'd4;
    localparam logic [SEC_W-1:0] SEC_MR = 3'd5;

    localparam int PQ_W = NQ_W + RECIP_DEN_W;
    localparam int PP_W = NP_W + RECIP_FS_W;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] en;

    logic [SEC_W-1:0]  sec_reg [STAGES];
    logic              noise_reg [STAGES];

    logic [FRAC_W-1:0] frac_reg;
    logic [XQ_W-1:0]   xq_reg, xt_reg;
    logic [CH_W-1:0]   xp_reg;
    logic [NQ_W-1:0]   nq_g_reg, nt_g_reg, nq_h_reg, nt_h_reg;
    logic [NP_W-1:0]   np_g_reg, np_h_reg;
    logic [CH_W-1:0]   q0_reg, t0_reg, p0_reg;
    logic [CH_W-1:0]   q_reg, t_reg, p_reg;
    logic [CH_W-1:0]   red_reg, green_reg, blue_reg;

    always_comb
    begin
        en[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign hue_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= hue_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // sector and fraction
    logic [QUO_W-1:0]  h;
    logic [SEC_W-1:0]  sec_next;
    logic [FRAC_W-1:0] frac_next;

    assign h = hue.sat ? QUO_W'(HUE_FULL) : hue.quo;

    always_comb
    begin
        if (h >= QUO_W'(HUE_FULL))
        begin
            sec_next  = SEC_RY;
            frac_next = '0;
        end
        else if (h >= QUO_W'(5 * SECTOR_STEPS))
        begin
            sec_next  = SEC_MR;
            frac_next = FRAC_W'(h - QUO_W'(5 * SECTOR_STEPS));
        end
        else if (h >= QUO_W'(4 * SECTOR_STEPS))
        begin
            sec_next  = SEC_BM;
            frac_next = FRAC_W'(h - QUO_W'(4 * SECTOR_STEPS));
        end
        else if (h >= QUO_W'(3 * SECTOR_STEPS))
        begin
            sec_next  = SEC_CB;
            frac_next = FRAC_W'(h - QUO_W'(3 * SECTOR_STEPS));
        end
        else if (h >= QUO_W'(2 * SECTOR_STEPS))
        begin
            sec_next  = SEC_GC;
            frac_next = FRAC_W'(h - QUO_W'(2 * SECTOR_STEPS));
        end
        else if (h >= QUO_W'(SECTOR_STEPS))
        begin
            sec_next  = SEC_YG;
            frac_next = FRAC_W'(h - QUO_W'(SECTOR_STEPS));
        end
        else
        begin
            sec_next  = SEC_RY;
            frac_next = FRAC_W'(h);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sec_reg[0]   <= sec_next;
            noise_reg[0] <= hue.noise;
            frac_reg     <= frac_next;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (en[k])
            begin
                sec_reg[k]   <= sec_reg[k-1];
                noise_reg[k] <= noise_reg[k-1];
            end
        end
    end

    // numerators of q, t and p
    logic [XQ_W-1:0] sf, st;

    assign sf = XQ_W'(saturation) * XQ_W'(frac_reg);
    assign st = XQ_W'(saturation) * XQ_W'(FRAC_W'(SECTOR_STEPS) - frac_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            xq_reg <= XQ_W'(SCALE_DEN) - sf;
            xt_reg <= XQ_W'(SCALE_DEN) - st;
            xp_reg <= CH_W'(FULL_SCALE) - saturation;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            nq_g_reg <= NQ_W'(brightness) * NQ_W'(xq_reg);
            nt_g_reg <= NQ_W'(brightness) * NQ_W'(xt_reg);
            np_g_reg <= NP_W'(brightness) * NP_W'(xp_reg);
        end
    end

    // quotient estimates, at most one short
    logic [PQ_W-1:0] pq, pt;
    logic [PP_W-1:0] pp;

    assign pq = PQ_W'(nq_g_reg) * PQ_W'(RECIP_DEN);
    assign pt = PQ_W'(nt_g_reg) * PQ_W'(RECIP_DEN);
    assign pp = PP_W'(np_g_reg) * PP_W'(RECIP_FS);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            q0_reg   <= pq[RECIP_DEN_SH +: CH_W];
            t0_reg   <= pt[RECIP_DEN_SH +: CH_W];
            p0_reg   <= pp[RECIP_FS_SH +: CH_W];
            nq_h_reg <= nq_g_reg;
            nt_h_reg <= nt_g_reg;
            np_h_reg <= np_g_reg;
        end
    end

    // correction step
    logic [NQ_W-1:0] rq, rt;
    logic [NP_W-1:0] rp;

    assign rq = nq_h_reg - NQ_W'(q0_reg) * NQ_W'(SCALE_DEN);
    assign rt = nt_h_reg - NQ_W'(t0_reg) * NQ_W'(SCALE_DEN);
    assign rp = np_h_reg - NP_W'(p0_reg) * NP_W'(FULL_SCALE);

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            q_reg <= (rq >= NQ_W'(SCALE_DEN)) ? q0_reg + CH_W'(1) : q0_reg;
            t_reg <= (rt >= NQ_W'(SCALE_DEN)) ? t0_reg + CH_W'(1) : t0_reg;
            p_reg <= (rp >= NP_W'(FULL_SCALE)) ? p0_reg + CH_W'(1) : p0_reg;
        end
    end

    // channel selection and output register
    logic [CH_W-1:0] red_next, green_next, blue_next;

    always_comb
    begin
        if (noise_reg[4])
        begin
            red_next   = CH_W'(FULL_SCALE);
            green_next = '0;
            blue_next  = '0;
        end
        else
        begin
            case (sec_reg[4])
                SEC_RY:
                begin
                    red_next = brightness; green_next = t_reg; blue_next = p_reg;
                end
                SEC_YG:
                begin
                    red_next = q_reg; green_next = brightness; blue_next = p_reg;
                end
                SEC_GC:
                begin
                    red_next = p_reg; green_next = brightness; blue_next = t_reg;
                end
                SEC_CB:
                begin
                    red_next = p_reg; green_next = q_reg; blue_next = brightness;
                end
                SEC_BM:
                begin
                    red_next = t_reg; green_next = p_reg; blue_next = brightness;
                end
                default:
                begin
                    red_next = brightness; green_next = p_reg; blue_next = q_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

// File: hdl/cluster_label_to_hue_color.sv
// Top level of the cluster label to hue colour block: configuration registers and pipeline.
// Depends on clhc_pkg, clhc_hue_div and clhc_rgb.
//
// Usage:
//   Input channel in_valid/in_ready carries one label per transaction; the output
//   channel out_valid/out_ready carries one red/green/blue colour per transaction,
//   in input order. Label zero gives pure red.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 cluster
//   count, 1 saturation, 2 brightness) at the clock edge; other indexes are
//   ignored. Write only while no transaction is in flight.
//   Pipeline: 11 register stages (5 of hue division: the label*180 product, then
//   2 quotient bits per stage; 6 of colour conversion). The colour outputs are
//   driven straight from the output register.
//   Throughput: one transaction per cycle while the output is not stalled; each stage holds one item.
//   Stall: a stage holds while the one after it is full and stalled; empty
//   stages still fill, so input is taken until every stage is occupied.
//   Reset: pipeline emptied, count 1, saturation 255, brightness 255.
module cluster_label_to_hue_color
    import clhc_pkg::*;
#(
    parameter int LABEL_WIDTH = LABEL_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [LABEL_IN_W-1:0] label,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CH_W-1:0]       red,
    output logic [CH_W-1:0]       green,
    output logic [CH_W-1:0]       blue
);

    logic [CNT_W-1:0] cluster_count_reg;
    logic [CH_W-1:0]  saturation_reg;
    logic [CH_W-1:0]  brightness_reg;

    logic hue_valid;
    logic hue_ready;
    hue_t hue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_count_reg <= CNT_W'(1);
            saturation_reg    <= CH_W'(FULL_SCALE);
            brightness_reg    <= CH_W'(FULL_SCALE);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CLUSTER_COUNT: cluster_count_reg <= cfg_data[CNT_W-1:0];
                REG_SATURATION:    saturation_reg    <= cfg_data[CH_W-1:0];
                REG_BRIGHTNESS:    brightness_reg    <= cfg_data[CH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    clhc_hue_div #(
        .LABEL_WIDTH (LABEL_WIDTH)
    ) u_hue_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .label         (label),
        .cluster_count (cluster_count_reg),
        .hue_valid     (hue_valid),
        .hue_ready     (hue_ready),
        .hue           (hue)
    );

    clhc_rgb u_rgb (
        .clk        (clk),
        .rst_n      (rst_n),
        .hue_valid  (hue_valid),
        .hue_ready  (hue_ready),
        .hue        (hue),
        .saturation (saturation_reg),
        .brightness (brightness_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

endmodule
